>>> design/tpnl_pkg.sv
package tpnl_pkg;

    localparam int DIFF_W          = 16;
    localparam int TIME_W          = 32;
    localparam int SLOT_W          = 7;
    localparam int EVENT_SLOTS_DEF = 100;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_END   = 1'b1
    } t_kind;

    typedef struct packed {
        logic [DIFF_W-1:0] phase_a;
        logic [DIFF_W-1:0] phase_b;
        logic [DIFF_W-1:0] phase_c;
        logic [TIME_W-1:0] stamp;
        logic              low_power;
    } t_sample;

    typedef struct packed {
        logic [DIFF_W-1:0] ab;
        logic [DIFF_W-1:0] bc;
        logic [DIFF_W-1:0] ca;
        logic [DIFF_W-1:0] level;
    } t_diffs;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] rec_time;
        logic [DIFF_W-1:0] ab;
        logic [DIFF_W-1:0] bc;
        logic [DIFF_W-1:0] ca;
        logic [TIME_W-1:0] peak_time;
        logic [DIFF_W-1:0] peak_ab;
        logic [DIFF_W-1:0] peak_bc;
        logic [DIFF_W-1:0] peak_ca;
    } t_record;

endpackage

>>> design/three_phase_neutral_loss_detector_top.sv
// channel | direction | handshake              | word
// sample  | in        | i_in_valid / o_in_stall   | three phase voltages, time, low power
// record  | out       | o_out_valid / i_out_stall | start or end record with peak snapshot
// config  | in        | i_cfg_valid / o_cfg_ready | diff threshold
//
// one sample a cycle while o_in_stall is low; a record made from a sample
// passes the input register, difference/decision logic and output register
// reset is synchronous, active low, and clears event state, snapshot and threshold
// a stalled output holds its record; the input stalls only once the input
// register is full and the output register cannot drain
module three_phase_neutral_loss_detector_top #(
    parameter int EVENT_SLOTS = tpnl_pkg::EVENT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_phase_a_voltage,
    input  logic [15:0] i_phase_b_voltage,
    input  logic [15:0] i_phase_c_voltage,
    input  logic [31:0] i_sample_time,
    input  logic        i_low_power,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_record_kind,
    output logic [6:0]  o_slot_index,
    output logic [31:0] o_record_time,
    output logic [15:0] o_diff_ab,
    output logic [15:0] o_diff_bc,
    output logic [15:0] o_diff_ca,
    output logic [31:0] o_peak_time,
    output logic [15:0] o_peak_ab,
    output logic [15:0] o_peak_bc,
    output logic [15:0] o_peak_ca,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_diff_threshold
);

    logic                        r_in_valid;
    tpnl_pkg::t_sample           r_in_sample;
    logic                        r_out_valid;
    tpnl_pkg::t_record           r_out_rec;
    logic [tpnl_pkg::DIFF_W-1:0] r_threshold;

    tpnl_pkg::t_diffs  diffs;
    tpnl_pkg::t_record res_rec;
    logic              res_valid;
    logic              out_free;
    logic              advance;
    logic              in_take;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    tpnl_diff u_diff (
        .i_sample (r_in_sample),
        .o_diffs  (diffs)
    );

    tpnl_event #(
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_event (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_sample    (r_in_sample),
        .i_diffs     (diffs),
        .i_threshold (r_threshold),
        .o_res_valid (res_valid),
        .o_record    (res_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_diff_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample.phase_a   <= i_phase_a_voltage;
            r_in_sample.phase_b   <= i_phase_b_voltage;
            r_in_sample.phase_c   <= i_phase_c_voltage;
            r_in_sample.stamp     <= i_sample_time;
            r_in_sample.low_power <= i_low_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_rec <= res_rec;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_record_kind = r_out_rec.kind;
    assign o_slot_index  = r_out_rec.slot;
    assign o_record_time = r_out_rec.rec_time;
    assign o_diff_ab     = r_out_rec.ab;
    assign o_diff_bc     = r_out_rec.bc;
    assign o_diff_ca     = r_out_rec.ca;
    assign o_peak_time   = r_out_rec.peak_time;
    assign o_peak_ab     = r_out_rec.peak_ab;
    assign o_peak_bc     = r_out_rec.peak_bc;
    assign o_peak_ca     = r_out_rec.peak_ca;

endmodule

>>> design/tpnl_diff.sv
module tpnl_diff (
    input  tpnl_pkg::t_sample i_sample,
    output tpnl_pkg::t_diffs  o_diffs
);

    function automatic logic [tpnl_pkg::DIFF_W-1:0] absdiff(
        input logic [tpnl_pkg::DIFF_W-1:0] x,
        input logic [tpnl_pkg::DIFF_W-1:0] y
    );
        absdiff = (x >= y) ? x - y : y - x;
    endfunction

    logic [tpnl_pkg::DIFF_W-1:0] ab;
    logic [tpnl_pkg::DIFF_W-1:0] bc;
    logic [tpnl_pkg::DIFF_W-1:0] ca;
    logic [tpnl_pkg::DIFF_W-1:0] m;

    always_comb begin
        ab = absdiff(i_sample.phase_a, i_sample.phase_b);
        bc = absdiff(i_sample.phase_b, i_sample.phase_c);
        ca = absdiff(i_sample.phase_c, i_sample.phase_a);
        m  = ab;
        if (bc > m) begin
            m = bc;
        end
        if (ca > m) begin
            m = ca;
        end
        o_diffs.ab    = ab;
        o_diffs.bc    = bc;
        o_diffs.ca    = ca;
        o_diffs.level = m;
    end

endmodule

>>> design/tpnl_event.sv
module tpnl_event #(
    parameter int EVENT_SLOTS = tpnl_pkg::EVENT_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  tpnl_pkg::t_sample           i_sample,
    input  tpnl_pkg::t_diffs            i_diffs,
    input  logic [tpnl_pkg::DIFF_W-1:0] i_threshold,
    output logic                        o_res_valid,
    output tpnl_pkg::t_record           o_record
);

    localparam logic [tpnl_pkg::SLOT_W-1:0] LAST_SLOT =
        tpnl_pkg::SLOT_W'(EVENT_SLOTS - 1);

    logic                        r_active;
    logic [tpnl_pkg::SLOT_W-1:0] r_slot;
    logic [tpnl_pkg::DIFF_W-1:0] r_peak_ab;
    logic [tpnl_pkg::DIFF_W-1:0] r_peak_bc;
    logic [tpnl_pkg::DIFF_W-1:0] r_peak_ca;
    logic [tpnl_pkg::DIFF_W-1:0] r_peak_level;
    logic [tpnl_pkg::TIME_W-1:0] r_peak_stamp;

    logic any_at;
    logic start;
    logic close;
    logic take;
    logic live;

    always_comb begin
        any_at = (i_diffs.ab >= i_threshold) || (i_diffs.bc >= i_threshold) ||
                 (i_diffs.ca >= i_threshold);
        start  = !r_active && any_at;
        close  = r_active && !any_at;
        // a start always retakes the snapshot
        take   = start || (i_diffs.ab > r_peak_level) ||
                 (i_diffs.bc > r_peak_level) || (i_diffs.ca > r_peak_level);
        live   = i_step && !i_sample.low_power;

        o_res_valid        = !i_sample.low_power && (start || close);
        o_record.kind      = close ? tpnl_pkg::KIND_END : tpnl_pkg::KIND_START;
        o_record.slot      = r_slot;
        o_record.rec_time  = i_sample.stamp;
        o_record.ab        = i_diffs.ab;
        o_record.bc        = i_diffs.bc;
        o_record.ca        = i_diffs.ca;
        o_record.peak_time = close ? r_peak_stamp : '0;
        o_record.peak_ab   = close ? r_peak_ab : '0;
        o_record.peak_bc   = close ? r_peak_bc : '0;
        o_record.peak_ca   = close ? r_peak_ca : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_slot       <= '0;
            r_peak_ab    <= '0;
            r_peak_bc    <= '0;
            r_peak_ca    <= '0;
            r_peak_level <= '0;
            r_peak_stamp <= '0;
        end else if (live) begin
            if (start) begin
                r_active <= 1'b1;
            end
            if (close) begin
                r_active <= 1'b0;
                r_slot   <= (r_slot >= LAST_SLOT) ? '0 : r_slot + tpnl_pkg::SLOT_W'(1);
            end
            if (take) begin
                r_peak_ab    <= i_diffs.ab;
                r_peak_bc    <= i_diffs.bc;
                r_peak_ca    <= i_diffs.ca;
                r_peak_level <= i_diffs.level;
                r_peak_stamp <= i_sample.stamp;
            end
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("event slot beyond last slot");

    a_level_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_peak_level >= r_peak_ab) && (r_peak_level >= r_peak_bc) &&
        (r_peak_level >= r_peak_ca) &&
        ((r_peak_level == r_peak_ab) || (r_peak_level == r_peak_bc) ||
         (r_peak_level == r_peak_ca)))
        else $error("peak level is not the snapshot maximum");

    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (live && start) |=> (r_active && r_peak_stamp == $past(i_sample.stamp)))
        else $error("start did not open event and take snapshot");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (live && close) |=> (!r_active && r_slot != $past(r_slot)))
        else $error("end did not close event and advance slot");

endmodule

>>> test/tpnl_record_checker.sv
module tpnl_record_checker #(
    parameter int EVENT_SLOTS = tpnl_pkg::EVENT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_phase_a,
    input  logic [15:0] i_phase_b,
    input  logic [15:0] i_phase_c,
    input  logic [31:0] i_stamp,
    input  logic        i_low_power,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_kind,
    input  logic [6:0]  i_slot,
    input  logic [31:0] i_rec_time,
    input  logic [15:0] i_ab,
    input  logic [15:0] i_bc,
    input  logic [15:0] i_ca,
    input  logic [31:0] i_peak_time,
    input  logic [15:0] i_peak_ab,
    input  logic [15:0] i_peak_bc,
    input  logic [15:0] i_peak_ca,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_threshold,

    output int          o_errors,
    output int          o_outstanding
);

    logic [15:0]       threshold;
    logic              in_event;
    logic [6:0]        slot;
    logic [15:0]       snap_ab, snap_bc, snap_ca, snap_level;
    logic [31:0]       snap_time;
    int                errors;
    tpnl_pkg::t_record due_records[$];

    function automatic logic [15:0] abs_gap(input logic [15:0] x, input logic [15:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    task automatic take_snapshot(input logic [15:0] ab, input logic [15:0] bc,
                                 input logic [15:0] ca, input logic [31:0] t);
        snap_ab    = ab;
        snap_bc    = bc;
        snap_ca    = ca;
        snap_level = ab;
        if (bc > snap_level) snap_level = bc;
        if (ca > snap_level) snap_level = ca;
        snap_time  = t;
    endtask

    // advances the event state by one sample and yields the record it causes
    task automatic follow_sample(input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] c, input logic [31:0] t,
                                 output bit emitted, output tpnl_pkg::t_record rec);
        logic [15:0] d_ab, d_bc, d_ca;
        logic        loud;
        d_ab    = abs_gap(a, b);
        d_bc    = abs_gap(b, c);
        d_ca    = abs_gap(c, a);
        loud    = (d_ab >= threshold) || (d_bc >= threshold) || (d_ca >= threshold);
        emitted = 0;
        rec     = '0;
        if (!in_event && loud) begin
            take_snapshot(d_ab, d_bc, d_ca, t);
            in_event     = 1'b1;
            rec.kind     = tpnl_pkg::KIND_START;
            rec.slot     = slot;
            rec.rec_time = t;
            rec.ab       = d_ab;
            rec.bc       = d_bc;
            rec.ca       = d_ca;
            emitted      = 1;
        end else if (in_event && !loud) begin
            in_event      = 1'b0;
            rec.kind      = tpnl_pkg::KIND_END;
            rec.slot      = slot;
            rec.rec_time  = t;
            rec.ab        = d_ab;
            rec.bc        = d_bc;
            rec.ca        = d_ca;
            rec.peak_time = snap_time;
            rec.peak_ab   = snap_ab;
            rec.peak_bc   = snap_bc;
            rec.peak_ca   = snap_ca;
            emitted       = 1;
            slot = (slot >= EVENT_SLOTS - 1) ? 7'd0 : slot + 7'd1;
        end
        // peak follows the samples whether or not an event is open
        if (d_ab > snap_level || d_bc > snap_level || d_ca > snap_level)
            take_snapshot(d_ab, d_bc, d_ca, t);
    endtask

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("record %s mismatch at %0t: expected %h, got %h",
                         name, $realtime, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        tpnl_pkg::t_record want;
        tpnl_pkg::t_record fresh;
        bit                emitted;
        if (!i_rst_n) begin
            threshold  = '0;
            in_event   = 1'b0;
            slot       = '0;
            snap_ab    = '0;
            snap_bc    = '0;
            snap_ca    = '0;
            snap_level = '0;
            snap_time  = '0;
            due_records.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_records.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected record at %0t: kind %b slot %0d time %h",
                                 $realtime, i_kind, i_slot, i_rec_time);
                end else begin
                    want = due_records.pop_front();
                    note_field("kind", 32'(want.kind), 32'(i_kind));
                    note_field("slot", 32'(want.slot), 32'(i_slot));
                    note_field("time", want.rec_time, i_rec_time);
                    note_field("diff_ab", 32'(want.ab), 32'(i_ab));
                    note_field("diff_bc", 32'(want.bc), 32'(i_bc));
                    note_field("diff_ca", 32'(want.ca), 32'(i_ca));
                    note_field("peak_time", want.peak_time, i_peak_time);
                    note_field("peak_ab", 32'(want.peak_ab), 32'(i_peak_ab));
                    note_field("peak_bc", 32'(want.peak_bc), 32'(i_peak_bc));
                    note_field("peak_ca", 32'(want.peak_ca), 32'(i_peak_ca));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                threshold = i_cfg_threshold;
            if (i_in_valid && !i_in_stall && !i_low_power) begin
                follow_sample(i_phase_a, i_phase_b, i_phase_c, i_stamp, emitted, fresh);
                if (emitted)
                    due_records.push_back(fresh);
            end
        end
        o_errors      <= errors;
        o_outstanding <= due_records.size();
    end

endmodule

>>> test/tb_three_phase_neutral_loss_detector_top.sv
module tb_three_phase_neutral_loss_detector_top;

    localparam int SLOTS = tpnl_pkg::EVENT_SLOTS_DEF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;

    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_phase_a_voltage;
    logic [15:0] i_phase_b_voltage;
    logic [15:0] i_phase_c_voltage;
    logic [31:0] i_sample_time;
    logic        i_low_power;

    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_record_kind;
    logic [6:0]  o_slot_index;
    logic [31:0] o_record_time;
    logic [15:0] o_diff_ab;
    logic [15:0] o_diff_bc;
    logic [15:0] o_diff_ca;
    logic [31:0] o_peak_time;
    logic [15:0] o_peak_ab;
    logic [15:0] o_peak_bc;
    logic [15:0] o_peak_ca;

    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_diff_threshold;

    int          errors;
    int          outstanding;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    logic [15:0] cur_threshold = '0;
    logic [31:0] stamp = '0;
    int          run_left = 0;
    bit          run_loud = 0;

    int          idle_plan[4]  = '{0, 57, 0, 35};
    int          stall_plan[4] = '{0, 0, 57, 35};
    logic [15:0] threshold_plan[8] = '{16'd1, 16'd300, 16'h8000, 16'hFFFF,
                                       16'd0, 16'd0, 16'd2500, 16'd40};

    always #6 i_clk = ~i_clk;

    three_phase_neutral_loss_detector_top #(
        .EVENT_SLOTS(SLOTS)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_phase_a_voltage   (i_phase_a_voltage),
        .i_phase_b_voltage   (i_phase_b_voltage),
        .i_phase_c_voltage   (i_phase_c_voltage),
        .i_sample_time       (i_sample_time),
        .i_low_power         (i_low_power),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_record_kind       (o_record_kind),
        .o_slot_index        (o_slot_index),
        .o_record_time       (o_record_time),
        .o_diff_ab           (o_diff_ab),
        .o_diff_bc           (o_diff_bc),
        .o_diff_ca           (o_diff_ca),
        .o_peak_time         (o_peak_time),
        .o_peak_ab           (o_peak_ab),
        .o_peak_bc           (o_peak_bc),
        .o_peak_ca           (o_peak_ca),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_diff_threshold(i_cfg_diff_threshold)
    );

    tpnl_record_checker #(
        .EVENT_SLOTS(SLOTS)
    ) record_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_phase_a      (i_phase_a_voltage),
        .i_phase_b      (i_phase_b_voltage),
        .i_phase_c      (i_phase_c_voltage),
        .i_stamp        (i_sample_time),
        .i_low_power    (i_low_power),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_kind         (o_record_kind),
        .i_slot         (o_slot_index),
        .i_rec_time     (o_record_time),
        .i_ab           (o_diff_ab),
        .i_bc           (o_diff_bc),
        .i_ca           (o_diff_ca),
        .i_peak_time    (o_peak_time),
        .i_peak_ab      (o_peak_ab),
        .i_peak_bc      (o_peak_bc),
        .i_peak_ca      (o_peak_ca),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_threshold(i_cfg_diff_threshold),
        .o_errors       (errors),
        .o_outstanding  (outstanding)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic push_sample(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [31:0] t,
                               input logic lp);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_phase_a_voltage <= a;
        i_phase_b_voltage <= b;
        i_phase_c_voltage <= c;
        i_sample_time     <= t;
        i_low_power       <= lp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drain every expected record, then let any silent sample leave the pipe
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        settle();
        i_cfg_valid          <= 1'b1;
        i_cfg_diff_threshold <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid   <= 1'b0;
        cur_threshold  = value;
    endtask

    // runs of quiet and loud samples so events open and close often
    task automatic build_sample(output logic [15:0] a, output logic [15:0] b,
                                output logic [15:0] c, output logic lp);
        int          pick;
        int          span;
        int          gap;
        logic [15:0] lo, hi, mid;
        pick = $urandom_range(99);
        lp   = ($urandom_range(99) < 6);
        if (run_left == 0) begin
            run_loud = ($urandom_range(1) != 0);
            run_left = $urandom_range(6, 1);
        end
        run_left--;
        if (pick < 15) begin
            a = 16'($urandom);
            b = 16'($urandom);
            c = 16'($urandom);
        end else if (!run_loud && cur_threshold != 0) begin
            span = cur_threshold - 1;
            lo   = 16'($urandom_range(65535 - span));
            a    = 16'(lo + $urandom_range(span));
            b    = 16'(lo + $urandom_range(span));
            c    = 16'(lo + $urandom_range(span));
            if (pick < 25) begin
                // widest gap that still stays below threshold
                a = lo;
                b = 16'(lo + span);
            end
        end else begin
            gap = (pick < 30) ? int'(cur_threshold)
                              : int'($urandom_range(65535, cur_threshold));
            lo  = 16'($urandom_range(65535 - gap));
            hi  = 16'(lo + gap);
            mid = 16'($urandom);
            case ($urandom_range(2))
                0: begin
                    {a, b, c} = {lo, hi, mid};
                end
                1: begin
                    {a, b, c} = {mid, lo, hi};
                end
                default: begin
                    {a, b, c} = {hi, mid, lo};
                end
            endcase
        end
    endtask

    initial begin
        logic [15:0] a, b, c;
        logic        lp;
        int          taken;
        i_rst_n              <= 1'b0;
        i_in_valid           <= 1'b0;
        i_phase_a_voltage    <= '0;
        i_phase_b_voltage    <= '0;
        i_phase_c_voltage    <= '0;
        i_sample_time        <= '0;
        i_low_power          <= 1'b0;
        i_cfg_valid          <= 1'b0;
        i_cfg_diff_threshold <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // threshold still at reset: every sample is loud, so the first opens and nothing closes
        push_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
        push_sample(16'hFFFF, 16'h0000, 16'hFFFF, 32'h0000_0001, 1'b0);
        push_sample(16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0002, 1'b1);
        push_sample(16'h1234, 16'h1234, 16'h1234, 32'h0000_0003, 1'b0);

        write_threshold(16'hFFFF);
        push_sample(16'hFFFF, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        push_sample(16'h0007, 16'h0007, 16'h0007, 32'h8000_0000, 1'b0);
        push_sample(16'h0000, 16'hFFFF, 16'h8000, 32'h5555_5555, 1'b0);
        push_sample(16'hFFFE, 16'h0000, 16'h0000, 32'hAAAA_AAAA, 1'b0);
        push_sample(16'h0000, 16'hFFFF, 16'h0000, 32'h0000_0010, 1'b1);

        write_threshold(16'h0100);
        push_sample(16'h0000, 16'h0100, 16'h0080, 32'h0000_0020, 1'b0);
        push_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0021, 1'b0);

        // raised threshold lets the snapshot move while no event is open
        write_threshold(16'h8000);
        push_sample(16'h0000, 16'h2000, 16'h1000, 32'h0000_0030, 1'b0);
        push_sample(16'h7FFF, 16'h0000, 16'h4000, 32'h0000_0031, 1'b0);
        push_sample(16'h0000, 16'h8000, 16'h8000, 32'h0000_0032, 1'b0);
        push_sample(16'h0001, 16'h0002, 16'h0003, 32'h0000_0033, 1'b0);
        stamp = 32'h0000_0040;

        for (int p = 0; p < 8; p++) begin
            idle_pct  = idle_plan[p % 4];
            stall_pct = stall_plan[p % 4];
            write_threshold((p == 5) ? 16'($urandom_range(65535)) : threshold_plan[p]);
            taken = 0;
            while (taken < 150) begin
                build_sample(a, b, c, lp);
                stamp = ($urandom_range(19) == 0) ? $urandom : stamp + $urandom_range(120, 1);
                push_sample(a, b, c, stamp, lp);
                if (!lp) taken++;
            end
        end

        settle();
        if (errors == 0 && outstanding == 0) begin
            $display("three_phase_neutral_loss_detector_top regression: pass");
        end else begin
            $display("three_phase_neutral_loss_detector_top regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("three_phase_neutral_loss_detector_top regression: fail");
        $finish;
    end

endmodule
